@@ design/dsel_pkg.sv @@
// shared types and codes for the depth sorted entry list
package dsel_pkg;

    // operation codes of an input beat
    typedef logic [1:0] op_t;
    localparam op_t OP_CLEAR  = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_DRAIN  = 2'd2;

    // one stored entry, without its link
    typedef struct packed {
        logic signed [31:0] depth;
        logic [15:0]        tag;
        logic [7:0]         colour;
        logic [3:0]         points;
    } entry_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_WRITE,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_LINK_NEW,
        ST_LINK_PREV,
        ST_DRAIN_RD,
        ST_DRAIN_LOAD
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic clear;
        logic ins_write;
        logic rd_en;
        logic advance;
        logic link_new;
        logic link_prev;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic walk_done;
        logic deeper;
        logic have_prev;
        logic last_beat;
        logic out_free;
    } status_t;

endpackage

@@ design/dsel_ctrl.sv @@
// controller state machine for the depth sorted entry list
module dsel_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    input  logic [1:0]          operation,
    output logic                stall,
    input  dsel_pkg::status_t   status,
    output dsel_pkg::cmd_t      cmd
);

    dsel_pkg::state_t state_reg;
    dsel_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsel_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsel_pkg::ST_IDLE:
            begin
                if (valid)
                begin
                    case (operation)
                        dsel_pkg::OP_INSERT:
                        begin
                            if (!status.full)
                            begin
                                state_next = dsel_pkg::ST_INS_WRITE;
                            end
                        end
                        dsel_pkg::OP_DRAIN:
                        begin
                            if (!status.empty)
                            begin
                                state_next = dsel_pkg::ST_DRAIN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = dsel_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            dsel_pkg::ST_INS_WRITE:
            begin
                state_next = dsel_pkg::ST_WALK_RD;
            end
            dsel_pkg::ST_WALK_RD:
            begin
                state_next = status.walk_done ? dsel_pkg::ST_LINK_NEW : dsel_pkg::ST_WALK_CMP;
            end
            dsel_pkg::ST_WALK_CMP:
            begin
                state_next = status.deeper ? dsel_pkg::ST_LINK_NEW : dsel_pkg::ST_WALK_RD;
            end
            dsel_pkg::ST_LINK_NEW:
            begin
                state_next = status.have_prev ? dsel_pkg::ST_LINK_PREV : dsel_pkg::ST_IDLE;
            end
            dsel_pkg::ST_LINK_PREV:
            begin
                state_next = dsel_pkg::ST_IDLE;
            end
            dsel_pkg::ST_DRAIN_RD:
            begin
                state_next = dsel_pkg::ST_DRAIN_LOAD;
            end
            dsel_pkg::ST_DRAIN_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_beat ? dsel_pkg::ST_IDLE : dsel_pkg::ST_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = dsel_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        stall         = (state_reg != dsel_pkg::ST_IDLE);
        cmd.accept    = (state_reg == dsel_pkg::ST_IDLE) && valid;
        cmd.clear     = cmd.accept && (operation == dsel_pkg::OP_CLEAR);
        cmd.ins_write = (state_reg == dsel_pkg::ST_INS_WRITE);
        cmd.rd_en     = ((state_reg == dsel_pkg::ST_WALK_RD) && !status.walk_done)
                        || (state_reg == dsel_pkg::ST_DRAIN_RD);
        cmd.advance   = (state_reg == dsel_pkg::ST_WALK_CMP) && !status.deeper;
        cmd.link_new  = (state_reg == dsel_pkg::ST_LINK_NEW);
        cmd.link_prev = (state_reg == dsel_pkg::ST_LINK_PREV);
        cmd.out_load  = (state_reg == dsel_pkg::ST_DRAIN_LOAD) && status.out_free;
    end

endmodule

@@ design/dsel_datapath.sv @@
// entry memories, chain walk registers and output register
module dsel_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dsel_pkg::cmd_t      cmd,
    output dsel_pkg::status_t   status,
    input  logic signed [31:0]  depth,
    input  logic [15:0]         tag,
    input  logic [7:0]          colour,
    input  logic [3:0]          point_count,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [15:0]         out_tag,
    output logic signed [31:0]  out_depth,
    output logic [7:0]          out_colour,
    output logic [3:0]          out_points,
    output logic                last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // entry storage
    dsel_pkg::entry_t       data_mem [CAPACITY];
    logic [IDX_W-1:0]       link_mem [CAPACITY];
    dsel_pkg::entry_t       rd_entry_reg;
    logic [IDX_W-1:0]       rd_link_reg;

    // list and walk state
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [IDX_W-1:0]       prev_reg, prev_next;
    logic                   have_prev_reg, have_prev_next;

    // latched insert beat
    dsel_pkg::entry_t       new_reg, new_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    dsel_pkg::entry_t       out_entry_reg, out_entry_next;
    logic                   last_reg, last_next;

    logic [IDX_W-1:0]       new_idx;
    logic [CNT_W-1:0]       k_inc;
    logic [IDX_W-1:0]       link_wr_addr;
    logic [IDX_W-1:0]       link_wr_data;

    assign new_idx = count_reg[IDX_W-1:0];
    assign k_inc   = k_reg + CNT_W'(1);

    // status toward the controller
    always_comb
    begin
        status.full      = (count_reg == CNT_W'(CAPACITY));
        status.empty     = (count_reg == '0);
        status.walk_done = (k_reg == count_reg);
        status.deeper    = (new_reg.depth > rd_entry_reg.depth);
        status.have_prev = have_prev_reg;
        status.last_beat = (k_inc == count_reg);
        status.out_free  = !out_valid_reg || !out_stall;
    end

    // entry data memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
        begin
            data_mem[new_idx] <= new_reg;
        end
        if (cmd.rd_en)
        begin
            rd_entry_reg <= data_mem[cur_reg];
        end
    end

    // link memory, new entry link or predecessor link
    assign link_wr_addr = cmd.link_prev ? prev_reg : new_idx;
    assign link_wr_data = cmd.link_prev ? new_idx : cur_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.link_new || cmd.link_prev)
        begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_link_reg <= link_mem[cur_reg];
        end
    end

    // next values of list, walk and output registers
    always_comb
    begin
        count_next     = count_reg;
        head_next      = head_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        new_next       = new_reg;
        out_valid_next = out_valid_reg;
        out_entry_next = out_entry_reg;
        last_next      = last_reg;

        if (cmd.accept)
        begin
            new_next.depth  = depth;
            new_next.tag    = tag;
            new_next.colour = colour;
            new_next.points = point_count;
            cur_next        = head_reg;
            k_next          = '0;
            have_prev_next  = 1'b0;
        end
        if (cmd.clear)
        begin
            count_next = '0;
            head_next  = '0;
        end
        // step past an entry at least as deep as the new one
        if (cmd.advance)
        begin
            prev_next      = cur_reg;
            have_prev_next = 1'b1;
            cur_next       = rd_link_reg;
            k_next         = k_inc;
        end
        // new entry becomes head when nothing precedes it
        if (cmd.link_new && !have_prev_reg)
        begin
            head_next  = new_idx;
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.link_prev)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        // output beat load or hand-off
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_entry_next = rd_entry_reg;
            last_next      = status.last_beat;
            cur_next       = rd_link_reg;
            k_next         = k_inc;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            k_reg         <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            k_reg         <= k_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        new_reg       <= new_next;
        out_entry_reg <= out_entry_next;
        last_reg      <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_tag    = out_entry_reg.tag;
    assign out_depth  = out_entry_reg.depth;
    assign out_colour = out_entry_reg.colour;
    assign out_points = out_entry_reg.points;
    assign last       = last_reg;

endmodule

@@ design/depth_sorted_entry_list.sv @@
// Depth sorted entry list: keeps up to CAPACITY entries in a table chained by next
// links, in descending depth order with equal depths in arrival order. A clear
// beat empties the list. An insert beat stores the entry in the next free slot and
// walks the chain from the head, passing each entry through a read state and a
// compare state, since the entry memory has one registered read port; an insert
// into a full table is dropped. A drain beat walks the chain and emits one result
// beat per entry, each read and then loaded into the output register, waiting
// while the output stalls, with last set on the final one; an empty list emits
// nothing. The input side takes the next beat while the final result still waits.
module depth_sorted_entry_list #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  logic [1:0]          operation,
    input  logic signed [31:0]  depth,
    input  logic [15:0]         tag,
    input  logic [7:0]          colour,
    input  logic [3:0]          point_count,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         out_tag,
    output logic signed [31:0]  out_depth,
    output logic [7:0]          out_colour,
    output logic [3:0]          out_points,
    output logic                last
);

    dsel_pkg::cmd_t    cmd;
    dsel_pkg::status_t status;

    // sequencing
    dsel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .operation (operation),
        .stall     (stall),
        .status    (status),
        .cmd       (cmd)
    );

    // storage and output register
    dsel_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .depth       (depth),
        .tag         (tag),
        .colour      (colour),
        .point_count (point_count),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_tag     (out_tag),
        .out_depth   (out_depth),
        .out_colour  (out_colour),
        .out_points  (out_points),
        .last        (last)
    );

    // an insert into a full table is dropped at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !stall && (operation == dsel_pkg::OP_INSERT) && status.full) |=> !stall)
        else $error("dropped insert kept the block busy");

    // a clear leaves the list empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !stall && (operation == dsel_pkg::OP_CLEAR)) |=> status.empty)
        else $error("list not empty after clear");

    // a drain of a non-empty list keeps the input side busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !stall && (operation == dsel_pkg::OP_DRAIN) && !status.empty) |=> stall)
        else $error("drain did not start");

    // a result beat appears only out of a running drain
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(stall))
        else $error("result beat outside a drain");

endmodule
